### rtl/core/gbf_pkg.sv
// ----------------------------------------------------------------------------
// Grid best-first path step package
// Shared sizes, codes, types and coordinate helpers for the path step unit.
// ----------------------------------------------------------------------------
package gbf_pkg;

   localparam int GRID_WIDTH  = 32;
   localparam int GRID_HEIGHT = 32;
   localparam int PATH_LIMIT  = 64;

   localparam int FIELD_W = 5;
   localparam int XW      = (GRID_WIDTH  > 1) ? $clog2(GRID_WIDTH)  : 1;
   localparam int YW      = (GRID_HEIGHT > 1) ? $clog2(GRID_HEIGHT) : 1;
   localparam int AW      = XW + YW;
   localparam int DEPTH   = GRID_HEIGHT << XW;
   localparam int CELL_COUNT = GRID_WIDTH * GRID_HEIGHT;
   localparam int DW      = ((XW > YW) ? XW : YW) + 1;
   localparam int LW      = $clog2(CELL_COUNT + 2);
   localparam int LEN_OUT_W = 10;
   localparam int LEN_MAX   = (1 << LEN_OUT_W) - 1;
   localparam int CHK_W     = 8;

   localparam logic [1:0] MARK_UNSEEN = 2'd0;
   localparam logic [1:0] MARK_OPEN   = 2'd1;
   localparam logic [1:0] MARK_CLOSED = 2'd2;

   localparam logic CMD_WRITE = 1'b0;
   localparam logic CMD_QUERY = 1'b1;

   typedef enum logic [2:0] {
      STATUS_WRITTEN   = 3'd0,
      STATUS_FOUND     = 3'd1,
      STATUS_UNREACH   = 3'd2,
      STATUS_AT_GOAL   = 3'd3,
      STATUS_TOO_LONG  = 3'd4
   } status_type;

   typedef enum logic [3:0] {
      ST_WIPE,
      ST_IDLE,
      ST_CLEAR,
      ST_SEED,
      ST_SCAN,
      ST_SCAN_LAST,
      ST_EVAL,
      ST_CLOSE,
      ST_NB_RD,
      ST_NB_CHK,
      ST_WALK_CHK,
      ST_WALK_STEP,
      ST_RESULT
   } state_type;

   typedef struct packed {
      logic          ok;
      logic [XW-1:0] x;
      logic [YW-1:0] y;
   } step_type;

   function automatic logic in_grid_x(input logic [FIELD_W-1:0] f);
      return CHK_W'(f) < CHK_W'(GRID_WIDTH);
   endfunction

   function automatic logic in_grid_y(input logic [FIELD_W-1:0] f);
      return CHK_W'(f) < CHK_W'(GRID_HEIGHT);
   endfunction

   function automatic logic [XW-1:0] fit_x(input logic [FIELD_W-1:0] f);
      logic [XW+FIELD_W-1:0] t;
      t = (XW+FIELD_W)'(f);
      return t[XW-1:0];
   endfunction

   function automatic logic [YW-1:0] fit_y(input logic [FIELD_W-1:0] f);
      logic [YW+FIELD_W-1:0] t;
      t = (YW+FIELD_W)'(f);
      return t[YW-1:0];
   endfunction

   function automatic logic [AW-1:0] cell_addr(input logic [XW-1:0] x,
                                               input logic [YW-1:0] y);
      return {y, x};
   endfunction

   // Slot 0 is y+1, slot 1 is x-1, slot 2 is y-1, slot 3 is x+1.
   function automatic step_type take_step(input logic [XW-1:0] x,
                                          input logic [YW-1:0] y,
                                          input logic [1:0]    k);
      step_type r;
      r.ok = 1'b0;
      r.x  = x;
      r.y  = y;
      case (k)
         2'd0: begin
            r.ok = (CHK_W'(y) + CHK_W'(1)) < CHK_W'(GRID_HEIGHT);
            r.y  = y + YW'(1);
         end
         2'd1: begin
            r.ok = (x != '0);
            r.x  = x - XW'(1);
         end
         2'd2: begin
            r.ok = (y != '0);
            r.y  = y - YW'(1);
         end
         default: begin
            r.ok = (CHK_W'(x) + CHK_W'(1)) < CHK_W'(GRID_WIDTH);
            r.x  = x + XW'(1);
         end
      endcase
      return r;
   endfunction

endpackage

### rtl/core/gbf_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port RAM
// One read or write address per cycle, read data registered.
// ----------------------------------------------------------------------------
module gbf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data_ff <= mem[addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/core/grid_best_first_path_step_unit.sv
// ----------------------------------------------------------------------------
// Grid best-first path step unit
// Holds a wall map, runs a greedy best-first search on a query and returns
// the first move and the path length toward the goal.
// ----------------------------------------------------------------------------
//  Channel  Direction  Contents
//  req_     in         tuser: command; tdata: map write cell or query cells
//  rsp_     out        tdata: status, direction, path_length
//
// A query first clears the mark memory in one pass over all DEPTH entries,
// then each search round scans all DEPTH entries of the mark memory (one
// read a cycle) and then works on the neighbors of the best open cell;
// the path found is walked back from the goal. Reset starts a pass that
// clears the wall map to open with req_tready low, then the control goes
// idle. One item is worked on at a time; a result waiting on rsp_ stalls
// only the finish of the next item.
// ----------------------------------------------------------------------------
module grid_best_first_path_step_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic        req_tuser,   // command
   input  logic [31:0] req_tdata,   // cell_x, cell_y, blocked, start_x,
                                    // start_y, goal_x, goal_y
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata    // status, direction, path_length
);

   localparam int AW = gbf_pkg::AW;
   localparam int XW = gbf_pkg::XW;
   localparam int YW = gbf_pkg::YW;
   localparam int DW = gbf_pkg::DW;
   localparam int LW = gbf_pkg::LW;

   gbf_pkg::state_type state_ff, state_in;

   logic [4:0] f_cell_x, f_cell_y, f_start_x, f_start_y, f_goal_x, f_goal_y;
   logic       f_blocked;

   logic [XW-1:0] sx_ff, sx_in, gx_ff, gx_in, cx_ff, cx_in;
   logic [YW-1:0] sy_ff, sy_in, gy_ff, gy_in, cy_ff, cy_in;
   logic [AW-1:0] sc_ff, sc_in, pa_ff, pa_in, ba_ff, ba_in, cur_ff, cur_in;
   logic          pv_ff, pv_in, found_ff, found_in;
   logic [DW-1:0] best_ff, best_in;
   logic [1:0]    bpar_ff, bpar_in, k_ff, k_in, first_ff, first_in;
   logic [LW-1:0] len_ff, len_in;
   logic [2:0]    res_status_ff, res_status_in;
   logic [1:0]    res_dir_ff, res_dir_in;
   logic [9:0]    res_len_ff, res_len_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [15:0]   rsp_data_ff, rsp_data_in;

   logic          wall_we, wall_wd, wall_rd;
   logic [AW-1:0] wall_addr;
   logic          node_we;
   logic [3:0]    node_wd, node_rd;
   logic [AW-1:0] node_addr;

   logic                accept, out_free, query_ok, hit;
   logic [DW-1:0]       mdist;
   gbf_pkg::step_type   nb, wk;
   logic [XW-1:0]       bx;
   logic [YW-1:0]       by;

   assign f_cell_x  = req_tdata[4:0];
   assign f_cell_y  = req_tdata[9:5];
   assign f_blocked = req_tdata[10];
   assign f_start_x = req_tdata[15:11];
   assign f_start_y = req_tdata[20:16];
   assign f_goal_x  = req_tdata[25:21];
   assign f_goal_y  = req_tdata[30:26];

   assign req_tready = (state_ff == gbf_pkg::ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign query_ok = gbf_pkg::in_grid_x(f_start_x) && gbf_pkg::in_grid_y(f_start_y)
                  && gbf_pkg::in_grid_x(f_goal_x) && gbf_pkg::in_grid_y(f_goal_y);

   always_comb begin
      logic [XW-1:0] px;
      logic [YW-1:0] py;
      logic [XW-1:0] ax;
      logic [YW-1:0] ay;
      px = pa_ff[XW-1:0];
      py = pa_ff[AW-1:XW];
      ax = (px > gx_ff) ? px - gx_ff : gx_ff - px;
      ay = (py > gy_ff) ? py - gy_ff : gy_ff - py;
      mdist = DW'(ax) + DW'(ay);
   end

   assign hit = pv_ff && (node_rd[1:0] == gbf_pkg::MARK_OPEN) && (mdist <= best_ff);
   assign bx  = cur_ff[XW-1:0];
   assign by  = cur_ff[AW-1:XW];
   assign nb  = gbf_pkg::take_step(bx, by, k_ff);
   assign wk  = gbf_pkg::take_step(cx_ff, cy_ff, node_rd[3:2]);

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         gbf_pkg::ST_WIPE: begin
            if (sc_ff == AW'(gbf_pkg::DEPTH - 1)) begin
               state_in = gbf_pkg::ST_IDLE;
            end
         end
         gbf_pkg::ST_IDLE: begin
            if (accept) begin
               if (req_tuser == gbf_pkg::CMD_WRITE) begin
                  state_in = gbf_pkg::ST_RESULT;
               end else if (!query_ok) begin
                  state_in = gbf_pkg::ST_RESULT;
               end else if (f_start_x == f_goal_x && f_start_y == f_goal_y) begin
                  state_in = gbf_pkg::ST_RESULT;
               end else begin
                  state_in = gbf_pkg::ST_CLEAR;
               end
            end
         end
         gbf_pkg::ST_CLEAR: begin
            if (sc_ff == AW'(gbf_pkg::DEPTH - 1)) begin
               state_in = gbf_pkg::ST_SEED;
            end
         end
         gbf_pkg::ST_SEED: state_in = gbf_pkg::ST_SCAN;
         gbf_pkg::ST_SCAN: begin
            if (sc_ff == AW'(gbf_pkg::DEPTH - 1)) begin
               state_in = gbf_pkg::ST_SCAN_LAST;
            end
         end
         gbf_pkg::ST_SCAN_LAST: state_in = gbf_pkg::ST_EVAL;
         gbf_pkg::ST_EVAL: begin
            state_in = found_ff ? gbf_pkg::ST_CLOSE : gbf_pkg::ST_RESULT;
         end
         gbf_pkg::ST_CLOSE: state_in = gbf_pkg::ST_NB_RD;
         gbf_pkg::ST_NB_RD: begin
            if (nb.ok) begin
               state_in = gbf_pkg::ST_NB_CHK;
            end else if (k_ff == 2'd3) begin
               state_in = (cur_ff == gbf_pkg::cell_addr(gx_ff, gy_ff))
                          ? gbf_pkg::ST_WALK_CHK : gbf_pkg::ST_SCAN;
            end
         end
         gbf_pkg::ST_NB_CHK: begin
            if (k_ff == 2'd3) begin
               state_in = (cur_ff == gbf_pkg::cell_addr(gx_ff, gy_ff))
                          ? gbf_pkg::ST_WALK_CHK : gbf_pkg::ST_SCAN;
            end else begin
               state_in = gbf_pkg::ST_NB_RD;
            end
         end
         gbf_pkg::ST_WALK_CHK: begin
            if ((cx_ff == sx_ff && cy_ff == sy_ff) || len_ff > LW'(gbf_pkg::CELL_COUNT)) begin
               state_in = gbf_pkg::ST_RESULT;
            end else begin
               state_in = gbf_pkg::ST_WALK_STEP;
            end
         end
         gbf_pkg::ST_WALK_STEP: begin
            state_in = wk.ok ? gbf_pkg::ST_WALK_CHK : gbf_pkg::ST_RESULT;
         end
         gbf_pkg::ST_RESULT: begin
            if (out_free) begin
               state_in = gbf_pkg::ST_IDLE;
            end
         end
         default: state_in = gbf_pkg::ST_IDLE;
      endcase
   end

   // Memory controls.
   always_comb begin
      wall_we   = 1'b0;
      wall_wd   = f_blocked;
      wall_addr = gbf_pkg::cell_addr(nb.x, nb.y);
      node_we   = 1'b0;
      node_wd   = {2'b00, gbf_pkg::MARK_UNSEEN};
      node_addr = sc_ff;
      unique case (state_ff)
         gbf_pkg::ST_WIPE: begin
            wall_we   = 1'b1;
            wall_wd   = 1'b0;
            wall_addr = sc_ff;
         end
         gbf_pkg::ST_IDLE: begin
            wall_addr = gbf_pkg::cell_addr(gbf_pkg::fit_x(f_cell_x),
                                           gbf_pkg::fit_y(f_cell_y));
            wall_we   = accept && (req_tuser == gbf_pkg::CMD_WRITE)
                     && gbf_pkg::in_grid_x(f_cell_x) && gbf_pkg::in_grid_y(f_cell_y);
         end
         gbf_pkg::ST_CLEAR: node_we = 1'b1;
         gbf_pkg::ST_SEED: begin
            node_we   = 1'b1;
            node_addr = gbf_pkg::cell_addr(sx_ff, sy_ff);
            node_wd   = {2'b00, gbf_pkg::MARK_OPEN};
         end
         gbf_pkg::ST_CLOSE: begin
            node_we   = 1'b1;
            node_addr = ba_ff;
            node_wd   = {bpar_ff, gbf_pkg::MARK_CLOSED};
         end
         gbf_pkg::ST_NB_RD: node_addr = gbf_pkg::cell_addr(nb.x, nb.y);
         gbf_pkg::ST_NB_CHK: begin
            node_addr = gbf_pkg::cell_addr(nb.x, nb.y);
            node_we   = !wall_rd && (node_rd[1:0] == gbf_pkg::MARK_UNSEEN);
            node_wd   = {k_ff + 2'd2, gbf_pkg::MARK_OPEN};
         end
         gbf_pkg::ST_WALK_CHK: node_addr = gbf_pkg::cell_addr(cx_ff, cy_ff);
         default: begin
         end
      endcase
   end

   // Datapath next values.
   always_comb begin
      sx_in = sx_ff;  sy_in = sy_ff;  gx_in = gx_ff;  gy_in = gy_ff;
      cx_in = cx_ff;  cy_in = cy_ff;
      sc_in = sc_ff;  pa_in = sc_ff;  pv_in = (state_ff == gbf_pkg::ST_SCAN);
      ba_in = ba_ff;  cur_in = cur_ff;  found_in = found_ff;
      best_in = best_ff;  bpar_in = bpar_ff;  k_in = k_ff;
      first_in = first_ff;  len_in = len_ff;
      res_status_in = res_status_ff;  res_dir_in = res_dir_ff;  res_len_in = res_len_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;

      if (hit) begin
         best_in  = mdist;
         ba_in    = pa_ff;
         bpar_in  = node_rd[3:2];
         found_in = 1'b1;
      end

      unique case (state_ff)
         gbf_pkg::ST_WIPE: sc_in = sc_ff + AW'(1);
         gbf_pkg::ST_IDLE: begin
            sx_in  = gbf_pkg::fit_x(f_start_x);
            sy_in  = gbf_pkg::fit_y(f_start_y);
            gx_in  = gbf_pkg::fit_x(f_goal_x);
            gy_in  = gbf_pkg::fit_y(f_goal_y);
            cx_in  = gbf_pkg::fit_x(f_goal_x);
            cy_in  = gbf_pkg::fit_y(f_goal_y);
            len_in = '0;
            first_in = 2'd0;
            sc_in  = '0;
            res_dir_in = 2'd0;
            res_len_in = '0;
            if (req_tuser == gbf_pkg::CMD_WRITE) begin
               res_status_in = gbf_pkg::STATUS_WRITTEN;
            end else if (!query_ok) begin
               res_status_in = gbf_pkg::STATUS_UNREACH;
            end else begin
               res_status_in = gbf_pkg::STATUS_AT_GOAL;
            end
         end
         gbf_pkg::ST_CLEAR: sc_in = sc_ff + AW'(1);
         gbf_pkg::ST_SEED: begin
            sc_in    = '0;
            best_in  = '1;
            found_in = 1'b0;
         end
         gbf_pkg::ST_SCAN: sc_in = sc_ff + AW'(1);
         gbf_pkg::ST_EVAL: begin
            res_status_in = gbf_pkg::STATUS_UNREACH;
         end
         gbf_pkg::ST_CLOSE: begin
            cur_in   = ba_ff;
            k_in     = 2'd0;
            sc_in    = '0;
            best_in  = '1;
            found_in = 1'b0;
         end
         gbf_pkg::ST_NB_RD: begin
            if (!nb.ok) begin
               k_in = k_ff + 2'd1;
            end
         end
         gbf_pkg::ST_NB_CHK: k_in = k_ff + 2'd1;
         gbf_pkg::ST_WALK_CHK: begin
            if (len_ff > LW'(gbf_pkg::PATH_LIMIT)) begin
               res_status_in = gbf_pkg::STATUS_TOO_LONG;
               res_dir_in    = 2'd0;
               res_len_in    = (len_ff > LW'(gbf_pkg::LEN_MAX))
                               ? 10'(gbf_pkg::LEN_MAX) : len_ff[9:0];
            end else begin
               res_status_in = gbf_pkg::STATUS_FOUND;
               res_dir_in    = first_ff;
               res_len_in    = len_ff[9:0];
            end
         end
         gbf_pkg::ST_WALK_STEP: begin
            first_in = node_rd[3:2];
            cx_in    = wk.x;
            cy_in    = wk.y;
            len_in   = len_ff + LW'(1);
            if (!wk.ok) begin
               if (len_ff + LW'(1) > LW'(gbf_pkg::PATH_LIMIT)) begin
                  res_status_in = gbf_pkg::STATUS_TOO_LONG;
                  res_dir_in    = 2'd0;
                  res_len_in    = (len_ff + LW'(1) > LW'(gbf_pkg::LEN_MAX))
                                  ? 10'(gbf_pkg::LEN_MAX) : 10'(len_ff + LW'(1));
               end else begin
                  res_status_in = gbf_pkg::STATUS_FOUND;
                  res_dir_in    = node_rd[3:2];
                  res_len_in    = 10'(len_ff + LW'(1));
               end
            end
         end
         gbf_pkg::ST_RESULT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {1'b0, res_len_ff, res_dir_ff, res_status_ff};
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= gbf_pkg::ST_WIPE;
         rsp_valid_ff <= 1'b0;
         pv_ff        <= 1'b0;
         sc_ff        <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         pv_ff        <= pv_in;
         sc_ff        <= sc_in;
      end
      sx_ff <= sx_in;  sy_ff <= sy_in;  gx_ff <= gx_in;  gy_ff <= gy_in;
      cx_ff <= cx_in;  cy_ff <= cy_in;
      pa_ff <= pa_in;  ba_ff <= ba_in;  cur_ff <= cur_in;
      found_ff <= found_in;  best_ff <= best_in;  bpar_ff <= bpar_in;
      k_ff <= k_in;  first_ff <= first_in;  len_ff <= len_in;
      res_status_ff <= res_status_in;  res_dir_ff <= res_dir_in;
      res_len_ff <= res_len_in;  rsp_data_ff <= rsp_data_in;
   end

   gbf_ram #(
      .WIDTH (1),
      .DEPTH (gbf_pkg::DEPTH)
   ) u_wall_ram (
      .clock   (clock),
      .wr_en   (wall_we),
      .addr    (wall_addr),
      .wr_data (wall_wd),
      .rd_data (wall_rd)
   );

   gbf_ram #(
      .WIDTH (4),
      .DEPTH (gbf_pkg::DEPTH)
   ) u_node_ram (
      .clock   (clock),
      .wr_en   (node_we),
      .addr    (node_addr),
      .wr_data (node_wd),
      .rd_data (node_rd)
   );

endmodule
